// ===== sv/spime_pkg.sv =====
// Package for the SPI mode 0 master byte engine.
// Holds shared constants, the bit phase enum and the payload and config structs.
`default_nettype none

package spime_pkg;

  // Width of the tick counter; saturates at its all-ones value
  localparam int TICK_COUNT_WIDTH = 16;
  localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

  localparam logic [7:0] DUMMY_BYTE = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] REG_SETUP_TICKS    = 2'd0;
  localparam logic [1:0] REG_PHASE_TICKS    = 2'd1;
  localparam logic [1:0] REG_CS_ACTIVE_HIGH = 2'd2;
  localparam logic [1:0] REG_CS_PRESENT     = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  SETUP_TICKS_RST = 8'd16;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd0;

  // Input opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_OFFER = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] tx_byte;
    logic       use_dummy;
    logic       last_byte;
    logic       cs_framed;
    logic       miso_level;
  } req_t;

  typedef struct packed {
    logic       sck_level;
    logic       mosi_level;
    logic       cs_level;
    logic       ready_res;
    logic       accepted;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  setup_ticks;
    logic [15:0] phase_ticks;
    logic        cs_active_high;
    logic        cs_present;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/spime_bit_engine.sv =====
// Bit engine of the SPI mode 0 master: phase state machine, tick counter,
// shift registers and chip-select state. Depends on spime_pkg.
`default_nettype none

module spime_bit_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire spime_pkg::req_t req,
  input  wire spime_pkg::cfg_t cfg,
  output spime_pkg::rsp_t     result
);
  import spime_pkg::*;

  phase_t                      bit_phase, bit_phase_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0]                  tx_shift, tx_shift_next;
  logic [7:0]                  rx_shift, rx_shift_next;
  logic                        in_transfer, in_transfer_next;
  logic                        ending_byte, ending_byte_next;
  logic                        framed_hold, framed_hold_next;
  logic                        cs_out, cs_out_next;
  logic                        sck_out, sck_out_next;
  logic                        mosi_out, mosi_out_next;

  logic       setup_done, phase_done;
  logic       acc, rxv;
  logic [7:0] rxb;
  logic [7:0] tx_load;
  logic [2:0] index_dec;

  // Wait ends at the limit or when the counter saturates
  assign setup_done = (32'(tick_count) >= 32'(cfg.setup_ticks)) || (tick_count == TICK_MAX);
  assign phase_done = (32'(tick_count) >= 32'(cfg.phase_ticks)) || (tick_count == TICK_MAX);
  assign tx_load    = req.use_dummy ? DUMMY_BYTE : req.tx_byte;
  assign index_dec  = bit_index - 3'd1;

  // State registers, advanced once per transfer on the request channel
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_phase   <= PH_IDLE;
      bit_index   <= 3'd7;
      tick_count  <= '0;
      tx_shift    <= '0;
      rx_shift    <= '0;
      in_transfer <= 1'b0;
      ending_byte <= 1'b0;
      framed_hold <= 1'b0;
      cs_out      <= 1'b1;
      sck_out     <= 1'b0;
      mosi_out    <= 1'b0;
    end else if (step) begin
      bit_phase   <= bit_phase_next;
      bit_index   <= bit_index_next;
      tick_count  <= tick_count_next;
      tx_shift    <= tx_shift_next;
      rx_shift    <= rx_shift_next;
      in_transfer <= in_transfer_next;
      ending_byte <= ending_byte_next;
      framed_hold <= framed_hold_next;
      cs_out      <= cs_out_next;
      sck_out     <= sck_out_next;
      mosi_out    <= mosi_out_next;
    end
  end

  // Next state and per-tick result
  always_comb begin
    bit_phase_next   = bit_phase;
    bit_index_next   = bit_index;
    tick_count_next  = tick_count;
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    in_transfer_next = in_transfer;
    ending_byte_next = ending_byte;
    framed_hold_next = framed_hold;
    cs_out_next      = cs_out;
    sck_out_next     = sck_out;
    mosi_out_next    = mosi_out;
    acc = 1'b0;
    rxv = 1'b0;
    rxb = 8'd0;

    case (bit_phase)
      PH_IDLE: begin
        if (req.opcode == OP_OFFER) begin
          acc = 1'b1;
          // first byte of a transfer fixes framing
          if (!in_transfer) begin
            in_transfer_next = 1'b1;
            if (cfg.cs_present) begin
              if (req.cs_framed) begin
                cs_out_next      = cfg.cs_active_high;
                framed_hold_next = 1'b1;
              end else begin
                cs_out_next      = ~cfg.cs_active_high;
                framed_hold_next = 1'b0;
              end
            end else begin
              framed_hold_next = 1'b0;
            end
          end
          tx_shift_next    = tx_load;
          rx_shift_next    = 8'd0;
          ending_byte_next = req.last_byte;
          bit_index_next   = 3'd7;
          sck_out_next     = 1'b0;
          mosi_out_next    = tx_load[7];
          tick_count_next  = TICK_COUNT_WIDTH'(1);
          bit_phase_next   = PH_SETUP;
        end
      end
      PH_SETUP: begin
        if (setup_done) begin
          sck_out_next    = 1'b1;
          tick_count_next = '0;
          bit_phase_next  = PH_HIGH;
        end else begin
          tick_count_next = tick_count + TICK_COUNT_WIDTH'(1);
        end
      end
      PH_HIGH: begin
        // sample MISO as SCK falls
        if (phase_done) begin
          rx_shift_next   = {rx_shift[6:0], req.miso_level};
          sck_out_next    = 1'b0;
          tick_count_next = '0;
          bit_phase_next  = PH_LOW;
        end else begin
          tick_count_next = tick_count + TICK_COUNT_WIDTH'(1);
        end
      end
      default: begin
        if (phase_done) begin
          if (bit_index != 3'd0) begin
            bit_index_next  = index_dec;
            mosi_out_next   = tx_shift[index_dec];
            tick_count_next = TICK_COUNT_WIDTH'(1);
            bit_phase_next  = PH_SETUP;
          end else begin
            // byte complete
            rxv             = 1'b1;
            rxb             = rx_shift;
            tick_count_next = '0;
            bit_index_next  = 3'd7;
            bit_phase_next  = PH_IDLE;
            if (ending_byte) begin
              if (framed_hold && cfg.cs_present) cs_out_next = ~cfg.cs_active_high;
              framed_hold_next = 1'b0;
              in_transfer_next = 1'b0;
              ending_byte_next = 1'b0;
            end
          end
        end else begin
          tick_count_next = tick_count + TICK_COUNT_WIDTH'(1);
        end
      end
    endcase

    result.sck_level  = sck_out_next;
    result.mosi_level = mosi_out_next;
    result.cs_level   = cfg.cs_present ? cs_out_next : ~cfg.cs_active_high;
    result.ready_res  = (bit_phase == PH_IDLE);
    result.accepted   = acc;
    result.rx_valid   = rxv;
    result.rx_byte    = rxb;
  end

endmodule

`default_nettype wire

// ===== sv/spi_mode0_master_byte_engine_core.sv =====
// SPI mode 0 master byte engine, top level; uses spime_pkg and spime_bit_engine.
// Each request transfer is one tick of the bit engine and yields one response.
// The response is registered and valid in the cycle after the request is taken.
// Throughput: one request per cycle, limited only by stall on the response side.
// Reset: engine idle, CS at its inactive level, config registers at their defaults.
`default_nettype none

module spi_mode0_master_byte_engine_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire spime_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output spime_pkg::rsp_t      rsp,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);
  import spime_pkg::*;

  cfg_t cfg;
  rsp_t result;
  logic step;

  // Stall only while a finished response is held and blocked
  assign req_stall = rsp_valid && rsp_stall;
  assign step      = req_valid && !req_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks    <= SETUP_TICKS_RST;
      cfg.phase_ticks    <= PHASE_TICKS_RST;
      cfg.cs_active_high <= 1'b0;
      cfg.cs_present     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP_TICKS:    cfg.setup_ticks    <= cfg_data[7:0];
        REG_PHASE_TICKS:    cfg.phase_ticks    <= cfg_data;
        REG_CS_ACTIVE_HIGH: cfg.cs_active_high <= cfg_data[0];
        REG_CS_PRESENT:     cfg.cs_present     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  spime_bit_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .req    (req),
    .cfg    (cfg),
    .result (result)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp <= result;
    end
  end

  // A taken byte only when the engine was idle
  a_acc_ready: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.accepted) |-> rsp.ready_res)
    else $error("byte accepted while engine busy");

  // A completed byte leaves SCK low and is never taken in the same tick
  a_rx_sck_low: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.rx_valid) |-> (!rsp.sck_level && !rsp.accepted))
    else $error("byte completion with SCK high or a new byte taken");

  // No received data reported outside a completion
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.rx_valid) |-> (rsp.rx_byte == 8'd0))
    else $error("rx_byte non-zero without rx_valid");

  // Every taken request produces a response next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> rsp_valid)
    else $error("response missing after request transfer");

endmodule

`default_nettype wire
